FILE: hdl/foq_pkg.sv
// Package with the types, codes and sizes shared by the order queue modules.
package foq_pkg;

    localparam int QUEUE_DEPTH  = 64;
    localparam int PAYLOAD_BITS = 64;
    localparam int ID_BITS      = 31;

    typedef enum logic [2:0] {
        FN_ADD    = 3'd0,
        FN_CANCEL = 3'd1,
        FN_EXISTS = 3'd2,
        FN_PEEK   = 3'd3,
        FN_POP    = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [2:0]  func;
        logic [30:0] order_id;
        logic [63:0] order_payload;
    } t_cmd_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        present;
        logic [30:0] result_id;
        logic [63:0] result_payload;
    } t_result_item;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                    cmp;
        logic [ID_BITS-1:0]      cmp_id;
        logic                    write;
        logic [ID_BITS-1:0]      wr_id;
        logic [PAYLOAD_BITS-1:0] wr_payload;
        logic                    shift_sel;
        logic                    shift_all;
    } t_cell_ctrl;

endpackage

FILE: hdl/foq_cell.sv
// One queue position: holds an order, compares its id and shifts toward the head.
module foq_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  foq_pkg::t_cell_ctrl              i_ctrl,
    input  logic                             i_prev_valid,
    input  logic                             i_kill,
    input  logic                             i_next_valid,
    input  logic [foq_pkg::ID_BITS-1:0]      i_next_id,
    input  logic [foq_pkg::PAYLOAD_BITS-1:0] i_next_payload,
    output logic                             o_valid,
    output logic [foq_pkg::ID_BITS-1:0]      o_id,
    output logic [foq_pkg::PAYLOAD_BITS-1:0] o_payload,
    output logic                             o_match,
    output logic                             o_kill
);
    import foq_pkg::*;

    logic                    r_valid, n_valid;
    logic                    r_match, n_match;
    logic [ID_BITS-1:0]      r_id, n_id;
    logic [PAYLOAD_BITS-1:0] r_payload, n_payload;
    logic                    w_shift;
    logic                    w_tail;

    // On a cancel every cell at or behind the matched one takes its neighbor's contents; on a pop every cell does.
    assign o_kill  = i_kill | r_match;
    assign w_shift = i_ctrl.shift_all | (i_ctrl.shift_sel & o_kill);
    assign w_tail  = !r_valid && i_prev_valid;

    always_comb begin
        n_valid   = r_valid;
        n_id      = r_id;
        n_payload = r_payload;
        priority if (w_shift) begin
            n_valid   = i_next_valid;
            n_id      = i_next_id;
            n_payload = i_next_payload;
        end else if (i_ctrl.write && w_tail) begin
            n_valid   = 1'b1;
            n_id      = i_ctrl.wr_id;
            n_payload = i_ctrl.wr_payload;
        end else begin
            n_valid   = r_valid;
            n_id      = r_id;
            n_payload = r_payload;
        end
        n_match = r_match;
        if (i_ctrl.cmp) begin
            n_match = r_valid && (r_id == i_ctrl.cmp_id);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_match <= n_match;
        end
        r_id      <= n_id;
        r_payload <= n_payload;
    end

    assign o_valid   = r_valid;
    assign o_id      = r_id;
    assign o_payload = r_payload;
    assign o_match   = r_match;

endmodule

FILE: hdl/fifo_order_queue_with_cancel.sv
// Top level of the arrival-ordered order queue with cancel by id.
//
// For each command, in the cycle of the transfer every cell compares its stored
// id with the command's id into a match register, and in the following cycle
// the cells act (append at the tail, close a gap, shift out the head) while
// busy is high. The result appears on o_result with o_result_strobe high for
// exactly one cycle, the cycle after that; the receiver cannot stall it, and
// a new command may be started in that same cycle. The queue holds 64 orders,
// head at cell zero; there is no clearing pass after reset.
module fifo_order_queue_with_cancel (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  foq_pkg::t_cmd_item    i_cmd,
    output logic                  o_result_strobe,
    output foq_pkg::t_result_item o_result
);
    import foq_pkg::*;

    t_state       r_state, n_state;
    t_cmd_item    r_cmd;
    logic         r_strobe, n_strobe;
    t_result_item r_res, n_res;
    t_cell_ctrl   w_ctrl;

    logic [QUEUE_DEPTH-1:0]  w_valid;
    logic [QUEUE_DEPTH-1:0]  w_match;
    logic [QUEUE_DEPTH:0]    w_kill;
    logic [ID_BITS-1:0]      w_id      [QUEUE_DEPTH];
    logic [PAYLOAD_BITS-1:0] w_payload [QUEUE_DEPTH];

    logic                    w_found;
    logic [ID_BITS-1:0]      w_sel_id;
    logic [PAYLOAD_BITS-1:0] w_sel_payload;
    logic                    w_accept;

    assign w_accept  = start && !busy;
    assign busy      = (r_state == S_EXEC);
    assign w_kill[0] = 1'b0;
    assign w_found   = |w_match;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic                    w_prev_valid;
            logic                    w_next_valid;
            logic [ID_BITS-1:0]      w_next_id;
            logic [PAYLOAD_BITS-1:0] w_next_payload;

            if (g == 0) begin : g_head
                assign w_prev_valid = 1'b1;
            end else begin : g_body
                assign w_prev_valid = w_valid[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign w_next_valid   = 1'b0;
                assign w_next_id      = '0;
                assign w_next_payload = '0;
            end else begin : g_inner
                assign w_next_valid   = w_valid[g+1];
                assign w_next_id      = w_id[g+1];
                assign w_next_payload = w_payload[g+1];
            end

            foq_cell u_cell (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_ctrl         (w_ctrl),
                .i_prev_valid   (w_prev_valid),
                .i_kill         (w_kill[g]),
                .i_next_valid   (w_next_valid),
                .i_next_id      (w_next_id),
                .i_next_payload (w_next_payload),
                .o_valid        (w_valid[g]),
                .o_id           (w_id[g]),
                .o_payload      (w_payload[g]),
                .o_match        (w_match[g]),
                .o_kill         (w_kill[g+1])
            );
        end
    endgenerate

    // Ids are unique among valid cells, so at most one match bit is set.
    always_comb begin
        w_sel_id      = '0;
        w_sel_payload = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (w_match[i]) begin
                w_sel_id      = w_sel_id | w_id[i];
                w_sel_payload = w_sel_payload | w_payload[i];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_ctrl            = '0;
        w_ctrl.cmp        = w_accept;
        w_ctrl.cmp_id     = i_cmd.order_id;
        w_ctrl.wr_id      = r_cmd.order_id;
        w_ctrl.wr_payload = r_cmd.order_payload[PAYLOAD_BITS-1:0];
        n_strobe          = 1'b0;
        n_res             = '0;
        if (r_state == S_EXEC) begin
            n_strobe = 1'b1;
            unique case (r_cmd.func)
                FN_ADD: begin
                    priority if (w_found) begin
                        n_res.status = ST_DUPLICATE;
                    end else if (w_valid[QUEUE_DEPTH-1]) begin
                        n_res.status = ST_FULL;
                    end else begin
                        w_ctrl.write = 1'b1;
                    end
                end
                FN_CANCEL: begin
                    if (!w_found) begin
                        n_res.status = ST_NOT_FOUND;
                    end else begin
                        w_ctrl.shift_sel     = 1'b1;
                        n_res.result_id      = w_sel_id;
                        n_res.result_payload = 64'(w_sel_payload);
                    end
                end
                FN_EXISTS: begin
                    n_res.present = w_found;
                end
                FN_PEEK: begin
                    if (!w_valid[0]) begin
                        n_res.status = ST_EMPTY;
                    end else begin
                        n_res.result_id      = w_id[0];
                        n_res.result_payload = 64'(w_payload[0]);
                    end
                end
                FN_POP: begin
                    if (!w_valid[0]) begin
                        n_res.status = ST_EMPTY;
                    end else begin
                        w_ctrl.shift_all = 1'b1;
                    end
                end
                default: begin
                    n_res = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
        if (w_accept) begin
            r_cmd <= i_cmd;
        end
        r_res <= n_res;
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_res;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the order queue with cancel by id.
`timescale 1ns / 1ps

module tb_top;
    import foq_pkg::*;

    localparam int          CLK_HALF_NS     = 6;
    localparam int          RESET_CYCLES    = 7;
    localparam int          ITEM_TARGET     = 1400;
    localparam int          STALL_LIMIT     = 5000;
    localparam int          DRAIN_CYCLES    = 8;
    localparam int          RECENT_MAX      = 96;
    localparam logic [2:0]  FN_FIRST_UNUSED = 3'd5;

    typedef struct {
        t_cmd_item   cmd;
        int unsigned idle_pct;
    } t_queued_cmd;

    typedef struct {
        logic [ID_BITS-1:0]      id;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_resting_order;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    t_cmd_item    i_cmd = '0;
    logic         o_result_strobe;
    t_result_item o_result;

    t_queued_cmd        pending_cmds[$];
    t_result_item       expected_results[$];
    t_resting_order     order_book[$];
    logic [ID_BITS-1:0] recent_ids[$];
    int unsigned        cur_idle = 0;
    int unsigned        err_count = 0;
    int unsigned        stall_cycles = 0;

    fifo_order_queue_with_cancel dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

    initial begin
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // Applies one command to the shadow order book and returns its result.
    function automatic t_result_item apply_order_op(input t_cmd_item c);
        t_result_item r;
        int           pos;
        r   = '0;
        pos = -1;
        foreach (order_book[i]) begin
            if (pos < 0 && order_book[i].id == c.order_id) pos = i;
        end
        case (c.func)
            FN_ADD: begin
                if (pos >= 0) begin
                    r.status = ST_DUPLICATE;
                end else if (order_book.size() >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    order_book.insert(order_book.size(),
                                      '{id: c.order_id,
                                        payload: c.order_payload[PAYLOAD_BITS-1:0]});
                end
            end
            FN_CANCEL: begin
                if (pos < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.result_id      = order_book[pos].id;
                    r.result_payload = 64'(order_book[pos].payload);
                    order_book.delete(pos);
                end
            end
            FN_EXISTS: r.present = (pos >= 0);
            FN_PEEK: begin
                if (order_book.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.result_id      = order_book[0].id;
                    r.result_payload = 64'(order_book[0].payload);
                end
            end
            FN_POP: begin
                if (order_book.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    order_book.delete(0);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [ID_BITS-1:0] fresh_id();
        logic [ID_BITS-1:0] id;
        id = ID_BITS'($urandom);
        recent_ids.insert(recent_ids.size(), id);
        if (recent_ids.size() > RECENT_MAX) recent_ids.delete(0);
        return id;
    endfunction

    function automatic logic [ID_BITS-1:0] known_id();
        if (recent_ids.size() == 0) return ID_BITS'($urandom);
        return recent_ids[$urandom_range(0, recent_ids.size() - 1)];
    endfunction

    function automatic logic [63:0] rand_payload();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic push_cmd(input logic [2:0] f, input logic [ID_BITS-1:0] id,
                            input logic [63:0] pay);
        t_cmd_item c;
        c.func          = f;
        c.order_id      = id;
        c.order_payload = pay;
        pending_cmds.insert(pending_cmds.size(), '{cmd: c, idle_pct: cur_idle});
    endtask

    task automatic push_unused();
        push_cmd(3'(FN_FIRST_UNUSED + $urandom_range(0, 2)), ID_BITS'($urandom),
                 rand_payload());
    endtask

    // Mixed traffic; cancels, lookups and some adds aim at ids that were added not long ago.
    task automatic push_mix_burst(input int n);
        int unsigned r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                push_cmd(FN_ADD, ($urandom_range(0, 9) < 7) ? fresh_id() : known_id(),
                         rand_payload());
            end else if (r < 55) begin
                push_cmd(FN_CANCEL, ($urandom_range(0, 3) != 0) ? known_id()
                                                                : ID_BITS'($urandom),
                         rand_payload());
            end else if (r < 70) begin
                push_cmd(FN_EXISTS, $urandom_range(0, 1) ? known_id() : ID_BITS'($urandom),
                         rand_payload());
            end else if (r < 82) begin
                push_cmd(FN_PEEK, ID_BITS'($urandom), rand_payload());
            end else if (r < 95) begin
                push_cmd(FN_POP, ID_BITS'($urandom), rand_payload());
            end else begin
                push_unused();
            end
        end
    endtask

    // Fills the queue past its depth, probes it while full, then drains it.
    task automatic push_fill_burst();
        for (int k = 0; k < QUEUE_DEPTH + $urandom_range(2, 8); k++) begin
            push_cmd(FN_ADD, fresh_id(), rand_payload());
        end
        for (int k = 0; k < 3; k++) begin
            push_cmd(FN_ADD, known_id(), rand_payload());
            push_cmd(FN_ADD, fresh_id(), rand_payload());
        end
        push_cmd(FN_EXISTS, known_id(), rand_payload());
        push_cmd(FN_PEEK, ID_BITS'($urandom), rand_payload());
        for (int k = 0; k < QUEUE_DEPTH + 10; k++) begin
            if ($urandom_range(0, 9) < 6) begin
                push_cmd(FN_CANCEL, known_id(), rand_payload());
            end else begin
                push_cmd(FN_POP, ID_BITS'($urandom), rand_payload());
            end
        end
    endtask

    initial begin
        cur_idle = 31;
        // Directed opening: empty queue, id and payload extremes, gaps and unused codes.
        push_cmd(FN_PEEK,   '0, '0);
        push_cmd(FN_POP,    '0, '0);
        push_cmd(FN_CANCEL, 31'd5, '1);
        push_cmd(FN_EXISTS, '0, '0);
        push_cmd(FN_ADD,    '0, '0);
        push_cmd(FN_ADD,    '1, '1);
        push_cmd(FN_ADD,    '0, '1);
        push_cmd(FN_EXISTS, '0, '0);
        push_cmd(FN_EXISTS, '1, '0);
        push_cmd(FN_ADD,    31'h2AAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
        push_cmd(FN_ADD,    31'h5555_5555, 64'h5555_5555_5555_5555);
        push_cmd(FN_PEEK,   '1, '1);
        push_cmd(FN_CANCEL, 31'h2AAA_AAAA, '0);
        push_cmd(FN_PEEK,   '0, '0);
        push_cmd(FN_CANCEL, '1, '0);
        push_cmd(FN_FIRST_UNUSED, '1, '1);
        push_cmd(3'(FN_FIRST_UNUSED + 1), '0, '0);
        push_cmd(3'(FN_FIRST_UNUSED + 2), '1, '1);
        push_cmd(FN_POP,    '0, '0);
        push_cmd(FN_PEEK,   '0, '0);
        push_cmd(FN_CANCEL, 31'h5555_5555, '0);
        push_cmd(FN_PEEK,   '0, '0);
        push_cmd(FN_EXISTS, 31'h5555_5555, '0);
        push_cmd(FN_CANCEL, 31'h5555_5555, '0);
        push_cmd(FN_POP,    '0, '0);

        for (int phase = 0; phase < 3; phase++) begin
            cur_idle = (phase == 0) ? 31 : (phase == 1) ? 87 : 0;
            while (pending_cmds.size() < (phase + 1) * ITEM_TARGET / 3) begin
                if ($urandom_range(0, 5) == 0) begin
                    push_fill_burst();
                end else begin
                    push_mix_burst($urandom_range(20, 60));
                end
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // Command driver: a raised start is held until the transfer happens.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_results.insert(expected_results.size(), apply_order_op(i_cmd));
                pending_cmds.delete(0);
            end
            if (start && busy) begin
                // Hold the current command.
            end else if (pending_cmds.size() == 0) begin
                start <= 1'b0;
            end else if ($urandom_range(0, 99) < pending_cmds[0].idle_pct) begin
                start <= 1'b0;
            end else begin
                start <= 1'b1;
                i_cmd <= pending_cmds[0].cmd;
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_result_item exp_r;
        if (i_rst_n && o_result_strobe) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result expected none, actual %p", $time, o_result);
                err_count++;
            end else begin
                exp_r = expected_results[0];
                expected_results.delete(0);
                if (o_result.status !== exp_r.status) begin
                    $display("%0t: status expected %0d, actual %0d",
                             $time, exp_r.status, o_result.status);
                    err_count++;
                end
                if (o_result.present !== exp_r.present) begin
                    $display("%0t: present expected %0d, actual %0d",
                             $time, exp_r.present, o_result.present);
                    err_count++;
                end
                if (o_result.result_id !== exp_r.result_id) begin
                    $display("%0t: result_id expected %h, actual %h",
                             $time, exp_r.result_id, o_result.result_id);
                    err_count++;
                end
                if (o_result.result_payload !== exp_r.result_payload) begin
                    $display("%0t: result_payload expected %h, actual %h",
                             $time, exp_r.result_payload, o_result.result_payload);
                    err_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

FILE: sim.f
hdl/foq_pkg.sv
hdl/foq_cell.sv
hdl/fifo_order_queue_with_cancel.sv
tb/tb_top.sv
